FILE: hw/rtl/mmeu_pkg.sv
// constants, opcodes and helpers shared by the mini mips execute unit
// no dependencies
package mmeu_pkg;

    localparam int NumRegs   = 32;
    localparam int RegAw     = 5;
    localparam int DmemDepth = 4096;
    localparam int DmemAw    = 12;
    localparam int PcW       = 12;
    localparam int MemBase   = 1000;
    localparam logic [RegAw-1:0] LinkReg = 5'd31;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MULT = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_SLL  = 4'd4;
    localparam logic [3:0] OP_SRL  = 4'd5;
    localparam logic [3:0] OP_LI   = 4'd6;
    localparam logic [3:0] OP_BEQ  = 4'd7;
    localparam logic [3:0] OP_BNE  = 4'd8;
    localparam logic [3:0] OP_BGTZ = 4'd9;
    localparam logic [3:0] OP_BLEZ = 4'd10;
    localparam logic [3:0] OP_J    = 4'd11;
    localparam logic [3:0] OP_JAL  = 4'd12;
    localparam logic [3:0] OP_JR   = 4'd13;
    localparam logic [3:0] OP_LW   = 4'd14;
    localparam logic [3:0] OP_SW   = 4'd15;

    // request to the iterative multiply / divide unit
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] op_a;
        logic [31:0] op_b;
    } md_req_t;

    // register file reset value
    function automatic logic [31:0] reg_reset_val(input logic [RegAw-1:0] idx);
        logic [31:0] v;
        v = 32'd0;
        case (idx)
            5'd1:    v = 32'd5;
            5'd2:    v = 32'd10;
            5'd3:    v = 32'd20;
            5'd4:    v = 32'd30;
            5'd10:   v = 32'd1000;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/mini_mips_execute_unit_top.sv
// mini mips execute unit: one decoded instruction per item, one result per item
// register file (flops), data memory with clearing pass, pc, iterative mul/div
// depends on mmeu_pkg and mmeu_muldiv
//
// usage:
//   s_axis: tdata = {immediate, third_reg, second_reg, first_reg, command}
//   m_axis: tdata = {divide_by_zero, redirect, next_pc, reg_value,
//           reg_index, reg_write}, one result item per input item
// after reset a clearing pass walks the 4096-word data memory, one word a
//   cycle; no item is taken until it ends
// an item goes accept, execute, write back; simple ops and a zero divisor go
//   straight to write back, sw adds a memory step, lw one more for the registered
//   memory read, mult/div wait for the 32 one-bit steps of the shared multiply/divide unit
// one item is worked on at a time; s_axis_tready is low meanwhile
// the result sits in an output register until m_axis_tready; while it
//   waits the next item can be accepted and executed, and its result waits
//   for the register to free
// reset: registers take r1=5 r2=10 r3=20 r4=30 r10=1000, pc goes to 0
module mini_mips_execute_unit_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // command[3:0] first_reg[8:4] second_reg[13:9]
                                       // third_reg[18:14] immediate[34:19]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // reg_write[0] reg_index[5:1] reg_value[37:6]
                                       // next_pc[49:38] redirect[50] divide_by_zero[51]
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_MEM   = 3'd3;
    localparam logic [2:0] ST_MD    = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;
    localparam logic [2:0] ST_LOAD  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [mmeu_pkg::DmemAw-1:0] clr_reg;
    logic [31:0] regs_reg [mmeu_pkg::NumRegs];
    logic [31:0] dmem [mmeu_pkg::DmemDepth];
    logic [31:0] dmem_q_reg;
    logic [mmeu_pkg::PcW-1:0] pc_reg;

    logic [3:0]  cmd_reg;
    logic [4:0]  r1_reg, r3_reg;
    logic [15:0] imm_reg;
    logic [31:0] a_reg, b_reg, c_reg;
    logic [mmeu_pkg::DmemAw-1:0] addr_reg;

    // result being built and output register
    logic        wr_reg;
    logic [4:0]  widx_reg;
    logic [31:0] wval_reg;
    logic [11:0] npc_reg;
    logic        redir_reg, dz_reg;
    logic        ovalid_reg;
    logic [55:0] odata_reg;

    mmeu_pkg::md_req_t md_req;
    logic        md_done;
    logic [31:0] md_result;

    logic [31:0] imm_ext, sh_val, sh_mag;
    logic [mmeu_pkg::PcW-1:0] pc_inc;
    logic        taken;
    logic [31:0] alu_val;
    logic        alu_wr;
    logic [mmeu_pkg::DmemAw-1:0] addr_sum;
    logic        accept;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign imm_ext       = {{16{imm_reg[15]}}, imm_reg};
    assign pc_inc        = pc_reg + 12'd1;
    assign sh_mag        = (b_reg[31] ? (32'd0 - b_reg) : b_reg) >> r3_reg;
    assign sh_val        = b_reg[31] ? (32'd0 - sh_mag) : sh_mag;
    // address sum, low bits are the modulo by a power-of-two depth
    assign addr_sum      = mmeu_pkg::DmemAw'(mmeu_pkg::MemBase) + b_reg[mmeu_pkg::DmemAw-1:0]
                           + imm_reg[mmeu_pkg::DmemAw-1:0];

    // combinational results and branch decisions of the simple ops
    always_comb begin
        alu_val = 32'd0;
        alu_wr  = 1'b1;
        taken   = 1'b0;
        unique case (cmd_reg)
            mmeu_pkg::OP_ADD: alu_val = b_reg + c_reg;
            mmeu_pkg::OP_SUB: alu_val = b_reg - c_reg;
            mmeu_pkg::OP_SLL: alu_val = b_reg << r3_reg;
            mmeu_pkg::OP_SRL: alu_val = sh_val;
            mmeu_pkg::OP_LI:  alu_val = imm_ext;
            mmeu_pkg::OP_JAL: alu_val = {20'd0, pc_inc};
            mmeu_pkg::OP_BEQ: begin alu_wr = 1'b0; taken = (a_reg == b_reg); end
            mmeu_pkg::OP_BNE: begin alu_wr = 1'b0; taken = (a_reg != b_reg); end
            mmeu_pkg::OP_BGTZ: begin
                alu_wr = 1'b0; taken = !a_reg[31] && (a_reg != 32'd0);
            end
            mmeu_pkg::OP_BLEZ: begin
                alu_wr = 1'b0; taken = a_reg[31] || (a_reg == 32'd0);
            end
            default: alu_wr = 1'b0;
        endcase
    end

    assign md_req.start  = (state_reg == ST_EXEC) &&
                           (cmd_reg == mmeu_pkg::OP_MULT || cmd_reg == mmeu_pkg::OP_DIV) &&
                           !(cmd_reg == mmeu_pkg::OP_DIV && c_reg == 32'd0);
    assign md_req.is_div = (cmd_reg == mmeu_pkg::OP_DIV);
    assign md_req.op_a   = b_reg;
    assign md_req.op_b   = c_reg;

    mmeu_muldiv u_md (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .done    (md_done),
        .result  (md_result)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == mmeu_pkg::DmemAw'(mmeu_pkg::DmemDepth - 1))
                          state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_EXEC;
            ST_EXEC: begin
                if (md_req.start) state_next = ST_MD;
                else if (cmd_reg == mmeu_pkg::OP_LW || cmd_reg == mmeu_pkg::OP_SW)
                    state_next = ST_MEM;
                else state_next = ST_DONE;
            end
            ST_MEM:   state_next = (cmd_reg == mmeu_pkg::OP_LW) ? ST_LOAD : ST_DONE;
            ST_LOAD:  state_next = ST_DONE;
            ST_MD:    if (md_done) state_next = ST_DONE;
            ST_DONE:  if (!ovalid_reg || m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // data memory: clearing pass, store, registered read
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR)
            dmem[clr_reg] <= 32'd0;
        else if (state_reg == ST_MEM && cmd_reg == mmeu_pkg::OP_SW)
            dmem[addr_reg] <= a_reg;
        dmem_q_reg <= dmem[addr_reg];
    end

    // control, register file, pc
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            pc_reg     <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < mmeu_pkg::NumRegs; i++)
                regs_reg[i] <= mmeu_pkg::reg_reset_val(mmeu_pkg::RegAw'(i));
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + mmeu_pkg::DmemAw'(1);
            if (state_reg == ST_DONE && (!ovalid_reg || m_axis_tready)) begin
                ovalid_reg <= 1'b1;
                pc_reg     <= npc_reg;
                if (wr_reg) regs_reg[widx_reg] <= wval_reg;
            end else if (m_axis_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // operand capture and result build
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_axis_tdata[3:0];
            r1_reg  <= s_axis_tdata[8:4];
            r3_reg  <= s_axis_tdata[18:14];
            imm_reg <= s_axis_tdata[34:19];
            a_reg   <= regs_reg[s_axis_tdata[8:4]];
            b_reg   <= regs_reg[s_axis_tdata[13:9]];
            c_reg   <= regs_reg[s_axis_tdata[18:14]];
        end
        if (state_reg == ST_EXEC) begin
            addr_reg  <= addr_sum;
            wr_reg    <= alu_wr || cmd_reg == mmeu_pkg::OP_MULT || cmd_reg == mmeu_pkg::OP_DIV
                         || cmd_reg == mmeu_pkg::OP_LW;
            widx_reg  <= (cmd_reg == mmeu_pkg::OP_JAL) ? mmeu_pkg::LinkReg : r1_reg;
            wval_reg  <= alu_val;
            dz_reg    <= (cmd_reg == mmeu_pkg::OP_DIV) && (c_reg == 32'd0);
            redir_reg <= taken || cmd_reg == mmeu_pkg::OP_J || cmd_reg == mmeu_pkg::OP_JAL
                         || cmd_reg == mmeu_pkg::OP_JR;
            if (taken)
                npc_reg <= pc_reg + imm_reg[11:0];
            else if (cmd_reg == mmeu_pkg::OP_J || cmd_reg == mmeu_pkg::OP_JAL)
                npc_reg <= imm_reg[11:0];
            else if (cmd_reg == mmeu_pkg::OP_JR)
                npc_reg <= regs_reg[mmeu_pkg::LinkReg][11:0];
            else
                npc_reg <= pc_inc;
        end
        // store writes in ST_MEM; the registered lw word is taken in ST_LOAD
        if (state_reg == ST_LOAD)
            wval_reg <= dmem_q_reg;
        if (state_reg == ST_MD && md_done)
            wval_reg <= md_result;
        if (state_reg == ST_DONE && (!ovalid_reg || m_axis_tready))
            odata_reg <= {4'd0, dz_reg, redir_reg, npc_reg,
                          wr_reg ? wval_reg : 32'd0, wr_reg ? widx_reg : 5'd0, wr_reg};
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC |-> !s_axis_tready) else $error("ready while busy");
    a_one_out: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_EXEC) else $error("item not started");
    a_no_md_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        md_done |-> state_reg == ST_MD) else $error("stray muldiv done");

endmodule

FILE: hw/rtl/mmeu_muldiv.sv
// iterative multiply and signed divide, one bit per cycle
// depends on mmeu_pkg
module mmeu_muldiv (
    input  logic             aclk,
    input  logic             aresetn,
    input  mmeu_pkg::md_req_t req,
    output logic             done,
    output logic [31:0]      result
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        div_reg, div_next;
    logic        neg_reg, neg_next;
    logic [31:0] acc_reg, acc_next;   // product or remainder
    logic [31:0] q_reg, q_next;       // multiplier or dividend/quotient
    logic [31:0] d_reg, d_next;       // multiplicand or divisor magnitude
    logic [32:0] trial;
    logic [31:0] mag_a, mag_b;

    assign mag_a = req.op_a[31] ? (32'd0 - req.op_a) : req.op_a;
    assign mag_b = req.op_b[31] ? (32'd0 - req.op_b) : req.op_b;
    assign trial = {acc_reg, q_reg[31]} - {1'b0, d_reg};

    // operand load on start, then one step of shift-add or restoring divide
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            div_next  = req.is_div;
            neg_next  = req.op_a[31] ^ req.op_b[31];
            acc_next  = 32'd0;
            q_next    = req.is_div ? mag_a : req.op_b;
            d_next    = req.is_div ? mag_b : req.op_a;
        end else if (busy_reg) begin
            if (div_reg) begin
                if (!trial[32]) begin
                    acc_next = trial[31:0];
                    q_next   = {q_reg[30:0], 1'b1};
                end else begin
                    acc_next = {acc_reg[30:0], q_reg[31]};
                    q_next   = {q_reg[30:0], 1'b0};
                end
            end else begin
                acc_next = (acc_reg << 1) + (q_reg[31] ? d_reg : 32'd0);
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        div_reg <= div_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done   = busy_reg && !busy_next && !req.start;
    assign result = div_reg ? (neg_reg ? (32'd0 - q_next) : q_next) : acc_next;

    property p_no_restart;
        @(posedge aclk) disable iff (!aresetn) busy_reg && cnt_reg > 6'd1 |=> busy_reg;
    endproperty
    a_no_restart: assert property (p_no_restart) else $error("muldiv stopped early");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("done held");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 6'd32) else $error("count out of range");

endmodule

FILE: dv/mini_mips_execute_unit_top_tb.sv
// testbench for mini_mips_execute_unit_top: directed and random instruction streams
// depends on mmeu_pkg and the execute unit rtl; keeps its own register file, memory and pc
`timescale 1ns / 100ps

module mini_mips_execute_unit_top_tb;

    typedef struct packed {
        logic        dz;
        logic        redir;
        logic [11:0] npc;
        logic [31:0] wval;
        logic [4:0]  widx;
        logic        wr;
    } exec_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;

    // architectural shadow state
    logic [31:0] arch_regs [mmeu_pkg::NumRegs];
    logic [31:0] arch_mem [mmeu_pkg::DmemDepth];
    logic [11:0] arch_pc;

    exec_result_t pending_results[$];
    int          fail_count;
    int          result_count;
    int          item_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    longint      cycle_count;

    mini_mips_execute_unit_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // command first_reg second_reg third_reg immediate
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // reg_write reg_index reg_value next_pc redirect dz
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000) begin
            $display("timeout at %0t", $time);
            $display("FAIL mini_mips_execute_unit_top");
            $finish;
        end
    end

    function automatic logic [11:0] mem_addr(input logic [31:0] base, input logic [15:0] imm);
        longint sum;
        longint r;
        sum = longint'(mmeu_pkg::MemBase) + longint'($signed(base)) + longint'($signed(imm));
        r = sum % mmeu_pkg::DmemDepth;
        if (r < 0) r += mmeu_pkg::DmemDepth;
        return r[11:0];
    endfunction

    // execute one instruction on the shadow state
    function automatic exec_result_t execute_instr(input logic [3:0] cmd, input logic [4:0] ra,
                                                   input logic [4:0] rb, input logic [4:0] rc,
                                                   input logic [15:0] imm);
        exec_result_t res;
        logic [31:0] a, b, c, imm32, mag;
        logic [11:0] pc;
        longint q;
        a = arch_regs[ra];
        b = arch_regs[rb];
        c = arch_regs[rc];
        imm32 = {{16{imm[15]}}, imm};
        pc = arch_pc;
        res = '0;
        res.npc = pc + 12'd1;
        case (cmd)
            mmeu_pkg::OP_ADD:  begin res.wr = 1; res.widx = ra; res.wval = b + c; end
            mmeu_pkg::OP_SUB:  begin res.wr = 1; res.widx = ra; res.wval = b - c; end
            mmeu_pkg::OP_MULT: begin res.wr = 1; res.widx = ra; res.wval = b * c; end
            mmeu_pkg::OP_DIV: begin
                res.wr = 1; res.widx = ra;
                if (c == 0) begin
                    res.dz = 1;
                end else begin
                    q = longint'($signed(b)) / longint'($signed(c));
                    res.wval = q[31:0];
                end
            end
            mmeu_pkg::OP_SLL:  begin res.wr = 1; res.widx = ra; res.wval = b << rc; end
            mmeu_pkg::OP_SRL: begin
                res.wr = 1; res.widx = ra;
                if (b[31]) begin
                    mag = (32'd0 - b) >> rc;
                    res.wval = 32'd0 - mag;
                end else begin
                    res.wval = b >> rc;
                end
            end
            mmeu_pkg::OP_LI:   begin res.wr = 1; res.widx = ra; res.wval = imm32; end
            mmeu_pkg::OP_BEQ:  res.redir = (a == b);
            mmeu_pkg::OP_BNE:  res.redir = (a != b);
            mmeu_pkg::OP_BGTZ: res.redir = ($signed(a) > 0);
            mmeu_pkg::OP_BLEZ: res.redir = ($signed(a) <= 0);
            mmeu_pkg::OP_J:    begin res.redir = 1; res.npc = imm[11:0]; end
            mmeu_pkg::OP_JAL: begin
                res.redir = 1; res.npc = imm[11:0];
                res.wr = 1; res.widx = mmeu_pkg::LinkReg; res.wval = {20'd0, pc + 12'd1};
            end
            mmeu_pkg::OP_JR: begin
                res.redir = 1; res.npc = arch_regs[mmeu_pkg::LinkReg][11:0];
            end
            mmeu_pkg::OP_LW: begin
                res.wr = 1; res.widx = ra; res.wval = arch_mem[mem_addr(b, imm)];
            end
            default: arch_mem[mem_addr(b, imm)] = a;
        endcase
        if (res.redir && cmd >= mmeu_pkg::OP_BEQ && cmd <= mmeu_pkg::OP_BLEZ)
            res.npc = pc + imm[11:0];
        if (res.wr) arch_regs[res.widx] = res.wval;
        arch_pc = res.npc;
        return res;
    endfunction

    // send one item, predict at acceptance; tvalid stays up for a following item
    task automatic send_instr(input logic [3:0] cmd, input logic [4:0] ra, input logic [4:0] rb,
                              input logic [4:0] rc, input logic [15:0] imm);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tdata  <= {5'd0, imm, rc, rb, ra, cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        pending_results = {pending_results, execute_instr(cmd, ra, rb, rc, imm)};
        item_count++;
        @(negedge aclk);
    endtask

    // receiver stall
    always @(negedge aclk) begin
        if (aresetn) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        exec_result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[51:0];
            result_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.wr !== want.wr || got.widx !== want.widx || got.wval !== want.wval ||
                    got.npc !== want.npc || got.redir !== want.redir || got.dz !== want.dz) begin
                    $display("%0t: mismatch expected wr=%0d idx=%0d val=%h pc=%h rd=%0d dz=%0d",
                             $time, want.wr, want.widx, want.wval, want.npc, want.redir, want.dz);
                    $display("%0t:          actual   wr=%0d idx=%0d val=%h pc=%h rd=%0d dz=%0d",
                             $time, got.wr, got.widx, got.wval, got.npc, got.redir, got.dz);
                    fail_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // directed: every opcode and the corner cases
    task automatic test_directed();
        send_instr(mmeu_pkg::OP_ADD, 5'd5, 5'd1, 5'd2, 16'd0);
        send_instr(mmeu_pkg::OP_SUB, 5'd6, 5'd1, 5'd2, 16'd0);
        send_instr(mmeu_pkg::OP_LI, 5'd7, 5'd0, 5'd0, 16'h8000);
        send_instr(mmeu_pkg::OP_LI, 5'd8, 5'd0, 5'd0, 16'h7fff);
        send_instr(mmeu_pkg::OP_SLL, 5'd9, 5'd7, 5'd31, 16'd0);
        send_instr(mmeu_pkg::OP_SLL, 5'd11, 5'd11, 5'd0, 16'd0);
        send_instr(mmeu_pkg::OP_MULT, 5'd12, 5'd9, 5'd9, 16'd0);
        send_instr(mmeu_pkg::OP_LI, 5'd13, 5'd0, 5'd0, 16'hffff);
        // most negative over minus one, then a zero divisor
        send_instr(mmeu_pkg::OP_SLL, 5'd14, 5'd1, 5'd31, 16'd0);
        send_instr(mmeu_pkg::OP_SLL, 5'd14, 5'd14, 5'd0, 16'd0);
        send_instr(mmeu_pkg::OP_LI, 5'd15, 5'd0, 5'd0, 16'h0001);
        send_instr(mmeu_pkg::OP_SLL, 5'd15, 5'd15, 5'd31, 16'd0);
        send_instr(mmeu_pkg::OP_DIV, 5'd16, 5'd15, 5'd13, 16'd0);
        send_instr(mmeu_pkg::OP_DIV, 5'd17, 5'd2, 5'd20, 16'd0);
        send_instr(mmeu_pkg::OP_SRL, 5'd18, 5'd7, 5'd3, 16'd0);
        send_instr(mmeu_pkg::OP_SRL, 5'd19, 5'd13, 5'd31, 16'd0);
        send_instr(mmeu_pkg::OP_SW, 5'd8, 5'd10, 5'd0, 16'h8000);
        send_instr(mmeu_pkg::OP_LW, 5'd0, 5'd10, 5'd0, 16'h8000);
        send_instr(mmeu_pkg::OP_BEQ, 5'd1, 5'd1, 5'd0, 16'hffff);
        send_instr(mmeu_pkg::OP_BNE, 5'd1, 5'd2, 5'd0, 16'h0fff);
        send_instr(mmeu_pkg::OP_BGTZ, 5'd1, 5'd0, 5'd0, 16'h0010);
        send_instr(mmeu_pkg::OP_BLEZ, 5'd13, 5'd0, 5'd0, 16'h8000);
        send_instr(mmeu_pkg::OP_JAL, 5'd0, 5'd0, 5'd0, 16'h7fff);
        send_instr(mmeu_pkg::OP_J, 5'd0, 5'd0, 5'd0, 16'h0ffe);
        send_instr(mmeu_pkg::OP_JR, 5'd0, 5'd0, 5'd0, 16'd0);
        s_axis_tvalid <= 1'b0;
    endtask

    // random: half the items use a small register set and half the offsets are small, so loads hit stored words
    task automatic test_random(input int count);
        logic [3:0]  cmd;
        logic [15:0] imm;
        for (int i = 0; i < count; i++) begin
            cmd = 4'($urandom_range(15));
            if ((cmd == mmeu_pkg::OP_MULT || cmd == mmeu_pkg::OP_DIV) && $urandom_range(3) != 0)
                cmd = 4'($urandom_range(mmeu_pkg::OP_SRL + 1, mmeu_pkg::OP_SW));
            case ($urandom_range(3))
                0:       imm = 16'($urandom);
                1:       imm = 16'($urandom_range(7));
                2:       imm = 16'(-$urandom_range(8));
                default: imm = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            endcase
            if ($urandom_range(1))
                send_instr(cmd, 5'($urandom_range(7)), 5'($urandom_range(7)),
                           5'($urandom_range(7)), imm);
            else
                send_instr(cmd, 5'($urandom), 5'($urandom), 5'($urandom), imm);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        fail_count = 0;
        result_count = 0;
        item_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        arch_pc = '0;
        for (int i = 0; i < mmeu_pkg::NumRegs; i++)
            arch_regs[i] = mmeu_pkg::reg_reset_val(i[4:0]);
        for (int i = 0; i < mmeu_pkg::DmemDepth; i++) arch_mem[i] = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random(500);
        // sender holds off until the unit has drained
        wait_drained();
        send_idle_pct = 45;
        test_random(500);
        send_idle_pct = 0;
        recv_stall_pct = 45;
        test_random(500);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        test_random(500);
        recv_stall_pct = 0;

        wait_drained();
        repeat (100) @(posedge aclk);
        $display("sent %0d instructions over all opcodes, checked %0d results", item_count,
                 result_count);
        $display("idling phases: none, sender, receiver, both");
        if (fail_count == 0 && pending_results.size() == 0)
            $display("PASS mini_mips_execute_unit_top");
        else
            $display("FAIL mini_mips_execute_unit_top");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/mmeu_pkg.sv
hw/rtl/mmeu_muldiv.sv
hw/rtl/mini_mips_execute_unit_top.sv
dv/mini_mips_execute_unit_top_tb.sv
